// ===== sv/pqls_pkg.sv =====
// Package for the linear-scan priority queue.
// Holds the capacity constant, the entry, request and result types, the status codes and the FSM states.
// No dependencies.
package pqls_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int FILL_W = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] rank;
    status_t                  status;
    logic [FILL_W-1:0]        fill_level;
  } result_t;

endpackage

// ===== sv/pqls_mem.sv =====
// Entry store: one write port and one registered read port.
// Depends on pqls_pkg.
module pqls_mem (
  input  logic              clk,
  input  pqls_pkg::mem_req_t req,
  output pqls_pkg::entry_t   rd_data
);
  import pqls_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem_r[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/pqls_seq.sv =====
// Sequencer: accepts requests, scans the store with one rank comparator,
// closes the gap after a removal and holds the result. Depends on pqls_pkg.
module pqls_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [31:0]            in_item_value,
  input  logic signed [31:0]            in_item_rank,
  output pqls_pkg::mem_req_t             mem_req,
  input  pqls_pkg::entry_t               mem_rd_data,
  output logic                          res_valid,
  input  logic                          res_take,
  output pqls_pkg::result_t              res
);
  import pqls_pkg::*;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         p_r, p_nxt;
  logic [IDX_W-1:0]         best_r, best_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] rank_r, rank_nxt;
  status_t                  status_r, status_nxt;

  logic             accept;
  logic             full;
  logic             empty;
  logic             more;
  logic             take;
  logic [IDX_W-1:0] best_sel;

  assign accept = in_valid && in_ready;
  assign full   = (count_r >= CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign more   = ((CNT_W'(p_r) + CNT_W'(1)) < count_r);
  assign take   = (p_r == '0) || (mem_rd_data.rank > rank_r);
  assign best_sel = take ? p_r : best_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_DEQ && !empty) state_nxt = S_SCAN;
          else                           state_nxt = S_DONE;
        end
      end
      S_SCAN:  if (!more) state_nxt = S_SHIFT;
      S_SHIFT: if (!more) state_nxt = S_DONE;
      S_DONE:  if (res_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    p_nxt      = p_r;
    best_nxt   = best_r;
    val_nxt    = val_r;
    rank_nxt   = rank_r;
    status_nxt = status_r;
    mem_req    = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        mem_req.wr_addr = count_r[IDX_W-1:0];
        mem_req.wr_data = '{value: in_item_value, rank: in_item_rank};
        mem_req.rd_addr = '0;
        if (accept) begin
          val_nxt  = '0;
          rank_nxt = '0;
          p_nxt    = '0;
          best_nxt = '0;
          if (in_op == OP_ENQ) begin
            if (full) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              status_nxt    = ST_INSERTED;
              mem_req.wr_en = 1'b1;
              count_nxt     = count_r + CNT_W'(1);
            end
          end else if (empty) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            status_nxt = ST_REMOVED;
          end
        end
      end
      S_SCAN: begin
        if (take) begin
          val_nxt  = mem_rd_data.value;
          rank_nxt = mem_rd_data.rank;
        end
        best_nxt = best_sel;
        if (more) begin
          p_nxt           = p_r + IDX_W'(1);
          mem_req.rd_addr = p_r + IDX_W'(1);
        end else begin
          p_nxt           = best_sel;
          mem_req.rd_addr = best_sel + IDX_W'(1);
        end
      end
      S_SHIFT: begin
        mem_req.wr_addr = p_r;
        mem_req.wr_data = mem_rd_data;
        mem_req.rd_addr = p_r + IDX_W'(2);
        if (more) begin
          mem_req.wr_en = 1'b1;
          p_nxt         = p_r + IDX_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    p_r      <= p_nxt;
    best_r   <= best_nxt;
    val_r    <= val_nxt;
    rank_r   <= rank_nxt;
    status_r <= status_nxt;
  end

  assign res.value      = val_r;
  assign res.rank       = rank_r;
  assign res.status     = status_r;
  assign res.fill_level = FILL_W'(count_r);

  // checks
  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == OP_ENQ && !full |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("count not advanced on insert");
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SHIFT) |-> count_r != '0)
    else $error("scan on empty store");
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> CNT_W'(p_r) < count_r)
    else $error("shift pointer beyond fill");
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT && !more |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("count not lowered on removal");

endmodule

// ===== sv/priority_queue_linear_scan_top.sv =====
// Top level of the linear-scan priority queue: sequencer, entry store and result register.
// Depends on pqls_pkg, pqls_mem and pqls_seq.
//
// Holds up to DEPTH (16) value/rank pairs in arrival order. A request is taken only while
// the sequencer is idle; one result comes back per request. Insert, overflow and underflow
// results pass through the sequencer's result registers into the output register. A removal
// scans the entries through the single read port of the store with one signed comparator
// (ties keep the earlier entry), then moves each later entry down a slot. The output
// register lets a new request be accepted while the last result still waits to be taken.
module priority_queue_linear_scan_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_item_value,
  input  logic signed [31:0] in_item_rank,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_rank,
  output logic [1:0]         out_status,
  output logic [4:0]         out_fill_level
);
  import pqls_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rd_data;
  result_t  res;
  result_t  out_r;
  logic     res_valid;
  logic     res_take;
  logic     out_valid_r, out_valid_nxt;

  pqls_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  pqls_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_item_value (in_item_value),
    .in_item_rank  (in_item_rank),
    .mem_req       (mem_req),
    .mem_rd_data   (mem_rd_data),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  assign res_take = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) out_valid_nxt = 1'b1;
    else if (out_ready)        out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_r.value;
  assign out_rank       = out_r.rank;
  assign out_status     = out_r.status;
  assign out_fill_level = out_r.fill_level;

endmodule
